// File: src/mcbb_pkg.sv
// Shared constants, types and helpers of the maximum clique search block.
package mcbb_pkg;

    localparam int MAX_V = 128;
    localparam int VW    = $clog2(MAX_V);
    localparam int CW    = $clog2(MAX_V + 1);
    localparam int KW    = $clog2(MAX_V + 2);
    localparam int SAW   = $clog2(MAX_V * MAX_V);
    localparam int STW   = CW + VW;
    localparam int EW    = 7;
    localparam int CFG_W = 8;
    localparam int OUT_W = 8;

    typedef enum logic [4:0] {
        ST_IDLE, ST_E_RDU, ST_E_CHKU, ST_E_WRV, ST_E_DEGV,
        ST_O_START, ST_O_I, ST_O_DI, ST_O_J, ST_O_JC, ST_O_WR,
        ST_C_INIT, ST_C_LOOP, ST_C_RDROW, ST_C_ROW, ST_C_KRD, ST_C_KCHK, ST_C_WRC,
        ST_M_START, ST_M_RD, ST_M_WR, ST_M_NEXT, ST_M_END,
        ST_S_POP, ST_S_SZ, ST_S_PB, ST_S_ROWP, ST_S_F, ST_S_FC, ST_S_FEND, ST_S_BACK,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_E_RDU, OP_E_CHKU, OP_E_WRV, OP_E_DEGV,
        OP_O_START, OP_O_I, OP_O_DI, OP_O_J, OP_O_JC, OP_O_WR,
        OP_C_INIT, OP_C_LOOP, OP_C_RDROW, OP_C_ROW, OP_C_KRD, OP_C_KCHK, OP_C_WRC,
        OP_M_START, OP_M_RD, OP_M_WR, OP_M_NEXT, OP_M_END,
        OP_S_POP, OP_S_SZ, OP_S_PB, OP_S_ROWP, OP_S_F, OP_S_FC, OP_S_FEND, OP_S_BACK,
        OP_DONE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic edge_skip;
        logic i_eq_n;
        logic j_eq_n;
        logic i_eq_c;
        logic i_eq_sz;
        logic k_gt_max;
        logic cls_hit;
        logic pass_last;
        logic sz_zero;
        logic bound_ok;
        logic expand;
        logic d_zero;
        logic out_busy;
    } stat_t;

    function automatic logic [SAW-1:0] stack_addr(input logic [VW-1:0] lev,
                                                   input logic [CW-1:0] idx);
        stack_addr = SAW'(lev) * SAW'(MAX_V) + SAW'(idx);
    endfunction

endpackage

// File: src/mcbb_ram.sv
// Generic single write, single read memory with registered read data.
module mcbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/mcbb_ctrl.sv
// Sequencer for edge loading, vertex ordering, colouring and the clique search.
module mcbb_ctrl
    import mcbb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_solve,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = in_solve ? ST_O_START : ST_E_RDU;
            ST_E_RDU:    state_next = ST_E_CHKU;
            ST_E_CHKU:   state_next = stat.edge_skip ? ST_IDLE : ST_E_WRV;
            ST_E_WRV:    state_next = ST_E_DEGV;
            ST_E_DEGV:   state_next = ST_IDLE;
            ST_O_START:  state_next = ST_O_I;
            ST_O_I:      state_next = stat.i_eq_n ? ST_C_INIT : ST_O_DI;
            ST_O_DI:     state_next = ST_O_J;
            ST_O_J:      state_next = stat.j_eq_n ? ST_O_WR : ST_O_JC;
            ST_O_JC:     state_next = ST_O_J;
            ST_O_WR:     state_next = ST_O_I;
            ST_C_INIT:   state_next = ST_C_LOOP;
            ST_C_LOOP:   state_next = stat.i_eq_c ? ST_M_START : ST_C_RDROW;
            ST_C_RDROW:  state_next = ST_C_ROW;
            ST_C_ROW:    state_next = ST_C_KRD;
            ST_C_KRD:    state_next = stat.k_gt_max ? ST_C_WRC : ST_C_KCHK;
            ST_C_KCHK:   state_next = stat.cls_hit ? ST_C_KRD : ST_C_WRC;
            ST_C_WRC:    state_next = ST_C_LOOP;
            ST_M_START:  state_next = ST_M_RD;
            ST_M_RD:     state_next = stat.i_eq_c ? ST_M_NEXT : ST_M_WR;
            ST_M_WR:     state_next = ST_M_RD;
            ST_M_NEXT:   state_next = stat.pass_last ? ST_M_END : ST_M_RD;
            ST_M_END:    state_next = ST_S_POP;
            ST_S_POP:    state_next = ST_S_SZ;
            ST_S_SZ:     state_next = stat.sz_zero ? ST_S_BACK : ST_S_PB;
            ST_S_PB:     state_next = stat.bound_ok ? ST_S_ROWP : ST_S_BACK;
            ST_S_ROWP:   state_next = ST_S_F;
            ST_S_F:      state_next = stat.i_eq_sz ? ST_S_FEND : ST_S_FC;
            ST_S_FC:     state_next = ST_S_F;
            ST_S_FEND:   state_next = stat.expand ? ST_C_INIT : ST_S_POP;
            ST_S_BACK:   state_next = stat.d_zero ? ST_DONE : ST_S_POP;
            ST_DONE:     if (!stat.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:    cmd.op = OP_IDLE;
            ST_E_RDU:   cmd.op = OP_E_RDU;
            ST_E_CHKU:  cmd.op = OP_E_CHKU;
            ST_E_WRV:   cmd.op = OP_E_WRV;
            ST_E_DEGV:  cmd.op = OP_E_DEGV;
            ST_O_START: cmd.op = OP_O_START;
            ST_O_I:     cmd.op = OP_O_I;
            ST_O_DI:    cmd.op = OP_O_DI;
            ST_O_J:     cmd.op = OP_O_J;
            ST_O_JC:    cmd.op = OP_O_JC;
            ST_O_WR:    cmd.op = OP_O_WR;
            ST_C_INIT:  cmd.op = OP_C_INIT;
            ST_C_LOOP:  cmd.op = OP_C_LOOP;
            ST_C_RDROW: cmd.op = OP_C_RDROW;
            ST_C_ROW:   cmd.op = OP_C_ROW;
            ST_C_KRD:   cmd.op = OP_C_KRD;
            ST_C_KCHK:  cmd.op = OP_C_KCHK;
            ST_C_WRC:   cmd.op = OP_C_WRC;
            ST_M_START: cmd.op = OP_M_START;
            ST_M_RD:    cmd.op = OP_M_RD;
            ST_M_WR:    cmd.op = OP_M_WR;
            ST_M_NEXT:  cmd.op = OP_M_NEXT;
            ST_M_END:   cmd.op = OP_M_END;
            ST_S_POP:   cmd.op = OP_S_POP;
            ST_S_SZ:    cmd.op = OP_S_SZ;
            ST_S_PB:    cmd.op = OP_S_PB;
            ST_S_ROWP:  cmd.op = OP_S_ROWP;
            ST_S_F:     cmd.op = OP_S_F;
            ST_S_FC:    cmd.op = OP_S_FC;
            ST_S_FEND:  cmd.op = OP_S_FEND;
            ST_S_BACK:  cmd.op = OP_S_BACK;
            ST_DONE:    cmd.op = OP_DONE;
            default:    cmd.op = OP_IDLE;
        endcase
    end

endmodule

// File: src/mcbb_dp.sv
// Datapath: adjacency and degree stores, colouring stores, search stack and counters.
module mcbb_dp
    import mcbb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wen,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_fire,
    input  logic [EW-1:0]    edge_from,
    input  logic [EW-1:0]    edge_to,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [OUT_W-1:0] clique_size,
    input  cmd_t             cmd,
    output stat_t            stat
);

    logic [CFG_W-1:0] vc_reg;
    logic [EW-1:0]    u_reg, v_reg;
    logic [CW-1:0]    n_reg, i_reg, j_reg, rank_reg, c_reg, sz_reg, jw_reg;
    logic [CW-1:0]    best_reg, cur_reg, degi_reg, maxno_reg;
    logic [KW-1:0]    k_reg, kmin_reg;
    logic [VW-1:0]    cp_reg, d_reg, lev_reg, adj_ra_reg, deg_ra_reg;
    logic [MAX_V-1:0] row_reg, clsold_reg, adj_vld_reg, deg_vld_reg;
    logic [OUT_W-1:0] res_reg;
    logic             oval_reg;

    // memory ports
    logic             adj_we, deg_we, cls_we, col_we, wrk_we, stk_we, lvl_we;
    logic [VW-1:0]    adj_wa, adj_ra, deg_wa, deg_ra, col_wa, col_ra;
    logic [VW-1:0]    wrk_wa, wrk_ra, lvl_wa, lvl_ra;
    logic [CW-1:0]    cls_wa, cls_ra;
    logic [SAW-1:0]   stk_wa, stk_ra;
    logic [MAX_V-1:0] adj_wd, adj_rd, cls_wd, cls_rd;
    logic [CW-1:0]    deg_wd, deg_rd, lvl_wd, lvl_rd;
    logic [STW-1:0]   col_wd, col_rd, stk_wd, stk_rd;
    logic [VW-1:0]    wrk_wd, wrk_rd;

    logic [VW-1:0]    u_idx, v_idx;
    logic [MAX_V-1:0] adj_m;
    logic [CW-1:0]    deg_m, stk_b, col_k, cand_deg;
    logic [VW-1:0]    stk_p, col_p;
    logic [KW-1:0]    k_nx;
    logic             m_take;

    assign u_idx  = VW'(u_reg);
    assign v_idx  = VW'(v_reg);
    assign adj_m  = adj_vld_reg[adj_ra_reg] ? adj_rd : '0;
    assign deg_m  = deg_vld_reg[deg_ra_reg] ? deg_rd : '0;
    assign stk_b  = stk_rd[STW-1:VW];
    assign stk_p  = stk_rd[VW-1:0];
    assign col_k  = col_rd[STW-1:VW];
    assign col_p  = col_rd[VW-1:0];
    assign cand_deg = deg_m;
    assign k_nx   = (k_reg == '0) ? kmin_reg : k_reg + KW'(1);
    assign m_take = (k_reg == '0) ? (KW'(col_k) < kmin_reg) : (KW'(col_k) == k_reg);

    always_comb
    begin
        stat.edge_skip = (u_reg == v_reg) || (int'(u_reg) >= MAX_V) ||
                         (int'(v_reg) >= MAX_V) || adj_m[v_idx];
        stat.i_eq_n    = (i_reg == n_reg);
        stat.j_eq_n    = (j_reg == n_reg);
        stat.i_eq_c    = (i_reg == c_reg);
        stat.i_eq_sz   = (i_reg == sz_reg);
        stat.k_gt_max  = (k_reg > KW'(maxno_reg));
        stat.cls_hit   = |(row_reg & cls_rd);
        stat.pass_last = (k_nx > KW'(maxno_reg));
        stat.sz_zero   = (lvl_rd == '0);
        stat.bound_ok  = ((CW+1)'(d_reg) + (CW+1)'(stk_b)) > (CW+1)'(best_reg);
        stat.expand    = (c_reg != '0) && (d_reg != VW'(MAX_V - 1));
        stat.d_zero    = (d_reg == '0);
        stat.out_busy  = oval_reg;
    end

    // memory port steering
    always_comb
    begin
        adj_we = 1'b0; adj_wa = u_idx; adj_wd = adj_m | (MAX_V'(1) << v_idx);
        adj_ra = adj_ra_reg;
        deg_we = 1'b0; deg_wa = u_idx; deg_wd = deg_m + CW'(1); deg_ra = deg_ra_reg;
        cls_we = 1'b0; cls_wa = CW'(k_reg); cls_wd = clsold_reg | (MAX_V'(1) << cp_reg);
        cls_ra = CW'(k_reg);
        col_we = 1'b0; col_wa = VW'(i_reg); col_wd = {CW'(k_reg), cp_reg};
        col_ra = VW'(i_reg);
        wrk_we = 1'b0; wrk_wa = VW'(rank_reg); wrk_wd = VW'(i_reg); wrk_ra = VW'(i_reg);
        stk_we = 1'b0; stk_wa = stack_addr(lev_reg, jw_reg);
        stk_wd = {((k_reg == '0) ? CW'(0) : CW'(k_reg)), col_p};
        stk_ra = stack_addr(d_reg, i_reg);
        lvl_we = 1'b0; lvl_wa = d_reg; lvl_wd = stat.bound_ok ? sz_reg : '0;
        lvl_ra = d_reg;
        case (cmd.op)
            OP_E_RDU:   adj_ra = u_idx;
            OP_E_CHKU:
            begin
                adj_we = !stat.edge_skip;
                adj_ra = v_idx;
                deg_ra = u_idx;
            end
            OP_E_WRV:
            begin
                adj_we = 1'b1;
                adj_wa = v_idx;
                adj_wd = adj_m | (MAX_V'(1) << u_idx);
                deg_we = 1'b1;
                deg_ra = v_idx;
            end
            OP_E_DEGV:
            begin
                deg_we = 1'b1;
                deg_wa = v_idx;
            end
            OP_O_I:     deg_ra = VW'(i_reg);
            OP_O_J:     deg_ra = VW'(j_reg);
            OP_O_WR:    wrk_we = 1'b1;
            OP_C_RDROW: adj_ra = wrk_rd;
            OP_C_WRC:
            begin
                cls_we = 1'b1;
                col_we = 1'b1;
            end
            OP_M_WR:    stk_we = m_take;
            OP_M_END:
            begin
                lvl_we = 1'b1;
                lvl_wa = lev_reg;
                lvl_wd = jw_reg;
            end
            OP_S_SZ:    stk_ra = stack_addr(d_reg, lvl_rd - CW'(1));
            OP_S_PB:
            begin
                lvl_we = 1'b1;
                adj_ra = stk_p;
            end
            OP_S_FC:
            begin
                wrk_we = row_reg[stk_p];
                wrk_wa = VW'(c_reg);
                wrk_wd = stk_p;
            end
            default:    ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg      <= '0;
            adj_vld_reg <= '0;
            deg_vld_reg <= '0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                vc_reg <= cfg_wdata;
            end
            if (cmd.op == OP_E_CHKU && !stat.edge_skip)
            begin
                adj_vld_reg[u_idx] <= 1'b1;
            end
            if (cmd.op == OP_E_WRV)
            begin
                adj_vld_reg[v_idx] <= 1'b1;
                deg_vld_reg[u_idx] <= 1'b1;
            end
            if (cmd.op == OP_E_DEGV)
            begin
                deg_vld_reg[v_idx] <= 1'b1;
            end
            if (oval_reg && out_ready)
            begin
                oval_reg <= 1'b0;
            end
            else if (cmd.op == OP_DONE && !oval_reg)
            begin
                oval_reg <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        adj_ra_reg <= adj_ra;
        deg_ra_reg <= deg_ra;
        if (in_fire)
        begin
            u_reg <= edge_from;
            v_reg <= edge_to;
        end
        case (cmd.op)
            OP_O_START:
            begin
                n_reg    <= (int'(vc_reg) > MAX_V) ? CW'(MAX_V) : CW'(vc_reg);
                best_reg <= '0;
                cur_reg  <= '0;
                i_reg    <= '0;
            end
            OP_O_I:
            begin
                if (stat.i_eq_n)
                begin
                    c_reg   <= n_reg;
                    lev_reg <= '0;
                end
            end
            OP_O_DI:
            begin
                degi_reg <= deg_m;
                j_reg    <= '0;
                rank_reg <= '0;
            end
            OP_O_JC:
            begin
                if (cand_deg > degi_reg || (cand_deg == degi_reg && j_reg < i_reg))
                begin
                    rank_reg <= rank_reg + CW'(1);
                end
                j_reg <= j_reg + CW'(1);
            end
            OP_O_WR:    i_reg <= i_reg + CW'(1);
            OP_C_INIT:
            begin
                if ((KW'(best_reg) + KW'(1)) > KW'(cur_reg))
                begin
                    kmin_reg <= KW'(best_reg) + KW'(1) - KW'(cur_reg);
                end
                else
                begin
                    kmin_reg <= KW'(1);
                end
                maxno_reg <= CW'(1);
                i_reg     <= '0;
            end
            OP_C_RDROW: cp_reg <= wrk_rd;
            OP_C_ROW:
            begin
                row_reg <= adj_m;
                k_reg   <= KW'(1);
            end
            OP_C_KRD:
            begin
                if (stat.k_gt_max)
                begin
                    clsold_reg <= '0;
                end
            end
            OP_C_KCHK:
            begin
                if (stat.cls_hit)
                begin
                    k_reg <= k_reg + KW'(1);
                end
                else
                begin
                    clsold_reg <= cls_rd;
                end
            end
            OP_C_WRC:
            begin
                if (stat.k_gt_max)
                begin
                    maxno_reg <= CW'(k_reg);
                end
                i_reg <= i_reg + CW'(1);
            end
            OP_M_START:
            begin
                i_reg  <= '0;
                k_reg  <= '0;
                jw_reg <= '0;
            end
            OP_M_WR:
            begin
                if (m_take)
                begin
                    jw_reg <= jw_reg + CW'(1);
                end
                i_reg <= i_reg + CW'(1);
            end
            OP_M_NEXT:
            begin
                k_reg <= k_nx;
                i_reg <= '0;
            end
            OP_M_END:   d_reg <= lev_reg;
            OP_S_SZ:    sz_reg <= lvl_rd - CW'(1);
            OP_S_PB:
            begin
                if (stat.bound_ok)
                begin
                    cur_reg <= CW'(d_reg) + CW'(1);
                end
            end
            OP_S_ROWP:
            begin
                row_reg <= adj_m;
                i_reg   <= '0;
                c_reg   <= '0;
            end
            OP_S_FC:
            begin
                if (row_reg[stk_p])
                begin
                    c_reg <= c_reg + CW'(1);
                end
                i_reg <= i_reg + CW'(1);
            end
            OP_S_FEND:
            begin
                if (stat.expand)
                begin
                    lev_reg <= d_reg + VW'(1);
                end
                else
                begin
                    best_reg <= (cur_reg > best_reg) ? cur_reg : best_reg;
                    cur_reg  <= CW'(d_reg);
                end
            end
            OP_S_BACK:
            begin
                if (!stat.d_zero)
                begin
                    d_reg    <= d_reg - VW'(1);
                    best_reg <= (cur_reg > best_reg) ? cur_reg : best_reg;
                    cur_reg  <= CW'(d_reg - VW'(1));
                end
            end
            OP_DONE:
            begin
                if (!oval_reg)
                begin
                    res_reg <= (int'(best_reg) > 255) ? OUT_W'(255) : OUT_W'(best_reg);
                end
            end
            default:    ;
        endcase
    end

    assign out_valid   = oval_reg;
    assign clique_size = res_reg;

    mcbb_ram #(.WIDTH(MAX_V), .DEPTH(MAX_V)) u_adj_ram (
        .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .raddr(adj_ra), .rdata(adj_rd)
    );
    mcbb_ram #(.WIDTH(CW), .DEPTH(MAX_V)) u_deg_ram (
        .clk(clk), .we(deg_we), .waddr(deg_wa), .wdata(deg_wd), .raddr(deg_ra), .rdata(deg_rd)
    );
    mcbb_ram #(.WIDTH(MAX_V), .DEPTH(MAX_V + 1)) u_cls_ram (
        .clk(clk), .we(cls_we), .waddr(cls_wa), .wdata(cls_wd), .raddr(cls_ra), .rdata(cls_rd)
    );
    mcbb_ram #(.WIDTH(STW), .DEPTH(MAX_V)) u_col_ram (
        .clk(clk), .we(col_we), .waddr(col_wa), .wdata(col_wd), .raddr(col_ra), .rdata(col_rd)
    );
    mcbb_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_wrk_ram (
        .clk(clk), .we(wrk_we), .waddr(wrk_wa), .wdata(wrk_wd), .raddr(wrk_ra), .rdata(wrk_rd)
    );
    mcbb_ram #(.WIDTH(STW), .DEPTH(MAX_V * MAX_V)) u_stk_ram (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
    );
    mcbb_ram #(.WIDTH(CW), .DEPTH(MAX_V)) u_lvl_ram (
        .clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd), .raddr(lvl_ra), .rdata(lvl_rd)
    );

endmodule

// File: src/max_clique_branch_bound.sv
// Edge request: taken while idle, then E_RDU and E_CHKU (an ignored edge stops there),
// then E_WRV and E_DEGV. Solve request: the vertices are ordered by degree, then greedily
// coloured vertex by vertex and class by class, and the search loop is data dependent;
// all stores sit behind single read port memories, one access per step.
// A finished result waits in an output register; edge requests are taken meanwhile.
// rst_n is asynchronous: the graph is empty, vertex_count is 0, no result pending.
module max_clique_branch_bound
    import mcbb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wen,
    input  logic [CFG_W-1:0] cfg_wdata,      // vertex_count
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // [6:0] edge_from, [13:7] edge_to, zero pad
    input  logic [0:0]       s_axis_tuser,   // [0] cmd: 0 add edge, 1 solve
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [7:0] clique_size
);

    cmd_t  cmd;
    stat_t stat;
    logic  in_fire;

    // A request is taken only when the sequencer is idle; the output slot is separate.
    assign in_fire = s_axis_tvalid && s_axis_tready;

    mcbb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_solve (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcbb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .in_fire     (in_fire),
        .edge_from   (s_axis_tdata[6:0]),
        .edge_to     (s_axis_tdata[13:7]),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .clique_size (m_axis_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

`ifndef SYNTH
    // a result appears only at the end of a search
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.op == OP_DONE))
        else $error("result raised outside search completion");

    // no request may be taken while the sequencer is busy
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (cmd.op == OP_IDLE))
        else $error("input ready while sequencer busy");
`endif

endmodule
